// ----- sv/sbph_pkg.sv -----
// ----------------------------------------------------------------------------
// sbph_pkg
// Shared types and constants of the strided byte-pair histogram.
// ----------------------------------------------------------------------------
package sbph_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned IdxW     = 2 * ByteW;
  localparam int unsigned TableDep = 1 << IdxW;
  localparam int unsigned DistW    = 9;
  localparam int unsigned OutW     = 32;

  typedef enum logic [1:0] {
    MODE_FEED    = 2'd0,
    MODE_QUERY   = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

endpackage

// ----- sv/strided_byte_pair_histogram_core.sv -----
// ----------------------------------------------------------------------------
// strided_byte_pair_histogram_core
// Counts byte pairs (byte seen pair_distance positions earlier, current byte)
// in a table of 65536 saturating counters, and answers single-counter queries.
// ----------------------------------------------------------------------------
// A feed or no-op request is taken every cycle outside the clearing pass. Feeds
// run through a three-step pipeline: the history RAM is read at accept, the
// counter RAM in stage s1, and the incremented counter is written back in
// stage s2, with a forwarding register covering back-to-back hits on the same
// counter. A query uses the same path and its result is loaded into the output
// register from stage s2; a further query is held off while one is in flight or
// its result waits in the output register. After reset, and after each restart
// request, the block clears the counter RAM one entry per cycle, over all 65536
// entries, and accepts no request during that pass; a restart also waits for
// pending counter updates to finish. Configuration writes are taken at all times.
module strided_byte_pair_histogram_core #(
  parameter int unsigned MAX_DISTANCE = 256,
  parameter int unsigned COUNT_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbph_pkg::DistW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [sbph_pkg::ByteW-1:0]    data_byte_i,
  input  logic [sbph_pkg::ByteW-1:0]    query_first_i,
  input  logic [sbph_pkg::ByteW-1:0]    query_second_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sbph_pkg::OutW-1:0]     pair_count_o,
  output logic                          saturated_o
);

  localparam int unsigned PtrW  = (MAX_DISTANCE > 1) ? $clog2(MAX_DISTANCE) : 1;
  localparam int unsigned FillW = $clog2(MAX_DISTANCE + 1);
  localparam int unsigned CmpW  = (FillW > sbph_pkg::DistW) ? FillW : sbph_pkg::DistW;
  localparam int unsigned SumW  = FillW + 1;
  localparam int unsigned WideW = (COUNT_BITS > sbph_pkg::OutW) ? COUNT_BITS
                                                                : sbph_pkg::OutW;

  sbph_pkg::state_e state_q, state_d;
  logic [sbph_pkg::IdxW-1:0] clr_cnt_q, clr_cnt_d;
  logic [sbph_pkg::DistW-1:0] dist_q;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  logic s1_v_q, s1_v_d, s1_query_q;
  logic [sbph_pkg::ByteW-1:0] s1_byte_q;
  logic [sbph_pkg::IdxW-1:0] s1_qidx_q;
  logic s2_v_q, s2_v_d, s2_query_q;
  logic [sbph_pkg::IdxW-1:0] s2_idx_q;
  logic fwd_v_q;
  logic [sbph_pkg::IdxW-1:0] fwd_idx_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic out_valid_q, out_valid_d;
  logic [sbph_pkg::OutW-1:0] pair_count_q;
  logic saturated_q;

  sbph_pkg::mode_e mode;
  logic clearing, accept, acc_feed, acc_query, acc_restart;
  logic [CmpW-1:0] dist_ext;
  logic [FillW-1:0] dist_cl;
  logic [SumW-1:0] slot_sum;
  logic [PtrW-1:0] slot;
  logic cnt_en;
  logic [sbph_pkg::ByteW-1:0] hist_rdata;
  logic [sbph_pkg::IdxW-1:0] s1_idx;
  logic [COUNT_BITS-1:0] cnt_rdata, cur_cnt, inc_cnt;
  logic cur_sat, s2_we;
  logic [WideW-1:0] cur_wide;
  logic cnt_we;
  logic [sbph_pkg::IdxW-1:0] cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  assign mode     = sbph_pkg::mode_e'(mode_i);
  assign clearing = (state_q == sbph_pkg::ST_CLEAR);

  always_comb begin
    in_ready_o = 1'b0;
    if (!clearing) begin
      unique case (mode)
        sbph_pkg::MODE_QUERY: begin
          in_ready_o = !(s1_v_q && s1_query_q) && !(s2_v_q && s2_query_q)
                       && (!out_valid_q || out_ready_i);
        end
        sbph_pkg::MODE_RESTART: begin
          in_ready_o = !s1_v_q && !s2_v_q;
        end
        default: begin
          in_ready_o = 1'b1;
        end
      endcase
    end
  end

  assign accept      = in_valid_i && in_ready_o;
  assign acc_feed    = accept && (mode == sbph_pkg::MODE_FEED);
  assign acc_query   = accept && (mode == sbph_pkg::MODE_QUERY);
  assign acc_restart = accept && (mode == sbph_pkg::MODE_RESTART);

  // Effective distance, clamped to the history depth.
  assign dist_ext = CmpW'(dist_q);
  assign dist_cl  = (dist_ext > CmpW'(MAX_DISTANCE)) ? FillW'(MAX_DISTANCE)
                                                     : FillW'(dist_ext);
  assign cnt_en   = (dist_cl != '0) && (fill_q >= dist_cl);
  assign slot_sum = SumW'(ptr_q) + SumW'(MAX_DISTANCE) - SumW'(dist_cl);
  assign slot     = (slot_sum >= SumW'(MAX_DISTANCE))
                    ? PtrW'(slot_sum - SumW'(MAX_DISTANCE)) : PtrW'(slot_sum);

  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    if (acc_restart) begin
      ptr_d  = '0;
      fill_d = '0;
    end else if (acc_feed) begin
      ptr_d  = (ptr_q == PtrW'(MAX_DISTANCE - 1)) ? '0 : ptr_q + PtrW'(1);
      fill_d = (fill_q < FillW'(MAX_DISTANCE)) ? fill_q + FillW'(1) : fill_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      sbph_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + sbph_pkg::IdxW'(1);
        if (clr_cnt_q == '1) begin
          state_d = sbph_pkg::ST_RUN;
        end
      end
      sbph_pkg::ST_RUN: begin
        if (acc_restart) begin
          state_d   = sbph_pkg::ST_CLEAR;
          clr_cnt_d = '0;
        end
      end
      default: begin
        state_d   = sbph_pkg::ST_CLEAR;
        clr_cnt_d = '0;
      end
    endcase
  end

  sbph_ram #(
    .Width (sbph_pkg::ByteW),
    .Depth (MAX_DISTANCE)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (acc_feed),
    .waddr_i (ptr_q),
    .wdata_i (data_byte_i),
    .raddr_i (slot),
    .rdata_o (hist_rdata)
  );

  assign s1_v_d = acc_query || (acc_feed && cnt_en);
  assign s1_idx = s1_query_q ? s1_qidx_q : {hist_rdata, s1_byte_q};
  assign s2_v_d = s1_v_q;

  assign cur_cnt  = (fwd_v_q && (fwd_idx_q == s2_idx_q)) ? fwd_data_q : cnt_rdata;
  assign cur_sat  = (cur_cnt == '1);
  assign inc_cnt  = cur_sat ? cur_cnt : cur_cnt + COUNT_BITS'(1);
  assign s2_we    = s2_v_q && !s2_query_q;
  assign cur_wide = WideW'(cur_cnt);

  assign cnt_we    = clearing || s2_we;
  assign cnt_waddr = clearing ? clr_cnt_q : s2_idx_q;
  assign cnt_wdata = clearing ? '0 : inc_cnt;

  sbph_ram #(
    .Width (COUNT_BITS),
    .Depth (sbph_pkg::TableDep)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (s1_idx),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_v_q && s2_query_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbph_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      dist_q      <= sbph_pkg::DistW'(1);
      ptr_q       <= '0;
      fill_q      <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      fwd_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      fwd_v_q     <= s2_we;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dist_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_query_q <= acc_query;
      s1_byte_q  <= data_byte_i;
      s1_qidx_q  <= {query_first_i, query_second_i};
    end
    if (s1_v_q) begin
      s2_query_q <= s1_query_q;
      s2_idx_q   <= s1_idx;
    end
    fwd_idx_q  <= s2_idx_q;
    fwd_data_q <= inc_cnt;
    if (s2_v_q && s2_query_q) begin
      pair_count_q <= (cur_wide > WideW'(32'hFFFF_FFFF)) ? '1
                                                          : cur_wide[sbph_pkg::OutW-1:0];
      saturated_q  <= cur_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pair_count_o = pair_count_q;
  assign saturated_o  = saturated_q;

  a_clear_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s2_v_q && !s1_v_q)
    else $error("Counter update in flight during the clearing pass.");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_query_q) |-> (!out_valid_q || out_ready_i))
    else $error("Query result would overwrite a result not yet taken.");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_restart |=> clearing && (clr_cnt_q == '0) && (fill_q == '0) && (ptr_q == '0))
    else $error("Restart did not start a clean clearing pass.");

  a_single_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({s1_v_q && s1_query_q, s2_v_q && s2_query_q}) <= 1)
    else $error("More than one query in the counter pipeline.");

endmodule

// ----- sv/sbph_ram.sv -----
// ----------------------------------------------------------------------------
// sbph_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module sbph_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule
